FILE: rtl/core/segment_segment_closest_points_unit_assert.svh
// Assertion macros used by the checker of this block.
`ifndef SEGMENT_SEGMENT_CLOSEST_POINTS_UNIT_ASSERT_SVH
`define SEGMENT_SEGMENT_CLOSEST_POINTS_UNIT_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define SSCP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sscp assertion failed");

// Clocked assertion that also holds through reset.
`define SSCP_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sscp reset assertion failed");

`endif

FILE: rtl/core/sscp_pkg.sv
`default_nettype none
package sscp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PW        = FRAC_BITS + 1;
    localparam int DW        = 140;
    localparam int QSH_R     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int QSH_L     = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

    localparam logic REG_EPS = 1'b0;
    localparam logic REG_TPE = 1'b1;

    typedef logic [2:0][31:0]   t_vec32;
    typedef logic [2:0][32:0]   t_vec33;
    typedef logic signed [67:0] t_dot;
    typedef logic signed [DW-1:0] t_wide;
    typedef logic [PW-1:0]      t_par;

    localparam t_par PAR_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [2:0] {
        M_BOTH, M_FIRST_DEG, M_SECOND_DEG, M_GEN, M_PAR2, M_PAR1
    } t_mode;

    typedef enum logic [1:0] {TG_NONE, TG_S, TG_T} t_tgt;

    typedef struct packed {
        logic signed [31:0] seg1_start_x;
        logic signed [31:0] seg1_start_y;
        logic signed [31:0] seg1_start_z;
        logic signed [31:0] seg1_end_x;
        logic signed [31:0] seg1_end_y;
        logic signed [31:0] seg1_end_z;
        logic signed [31:0] seg2_start_x;
        logic signed [31:0] seg2_start_y;
        logic signed [31:0] seg2_start_z;
        logic signed [31:0] seg2_end_x;
        logic signed [31:0] seg2_end_y;
        logic signed [31:0] seg2_end_z;
    } t_in;

    typedef struct packed {
        logic [16:0]        param_first;
        logic [16:0]        param_second;
        logic signed [31:0] near_first_x;
        logic signed [31:0] near_first_y;
        logic signed [31:0] near_first_z;
        logic signed [31:0] near_second_x;
        logic signed [31:0] near_second_y;
        logic signed [31:0] near_second_z;
        logic [63:0]        dist_squared;
        logic [1:0]         point_count;
        logic               last_result;
    } t_out;

    typedef struct packed {
        t_vec32 p1;
        t_vec32 p2;
        t_vec33 d1;
        t_vec33 d2;
        t_dot   a;
        t_dot   b;
        t_dot   c;
        t_dot   e;
        t_dot   f;
        t_mode  mode;
        t_tgt   tgt;
        t_par   s;
        t_par   t;
        t_par   sp;
        t_par   tp;
        logic   two;
    } t_ctx;

    typedef struct packed {
        t_wide num;
        t_wide den;
    } t_lane;

    typedef t_lane [2:0] t_lanes;
    typedef t_par  [2:0] t_quots;

    function automatic logic [16:0] to_q16(t_par v);
        return 17'((32'(v) >> QSH_R) << QSH_L);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sscp_front.sv
`default_nettype none
module sscp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  sscp_pkg::t_in   i_data,
    input  logic [31:0]     i_eps,
    input  logic            i_tpe,
    output logic            o_valid,
    output sscp_pkg::t_ctx  o_ctx,
    output sscp_pkg::t_lanes o_lanes
);
    import sscp_pkg::*;

    logic   r_v1, r_v2, r_v3, r_v4, r_v5;
    t_ctx   r_c1, r_c2, r_c3, r_c4, r_c5;
    t_vec33 r_r, r_rq, r_rp;
    logic signed [65:0] r_pr [7][3];
    logic signed [69:0] r_pp [4][4];
    t_dot   r_g, r_f2, r_g4, r_f24, r_g5, r_f25;
    logic   r_adeg, r_edeg, r_adeg4, r_edeg4;
    logic signed [135:0] r_ae, r_bb, r_bf, r_ce;

    t_ctx   n_c1, n_c3, n_c6;
    t_vec33 n_r, n_rq, n_rp;
    t_vec32 q1, q2;
    t_dot   n_g, n_f2;
    t_dot   mx [4];
    t_dot   my [4];
    t_lanes n_lanes;
    t_wide  denom, num, epsw, n0, n1;

    function automatic logic [32:0] sub33(logic [31:0] x, logic [31:0] y);
        return {x[31], x} - {y[31], y};
    endfunction

    function automatic t_dot dsum(logic signed [65:0] x, logic signed [65:0] y,
                                  logic signed [65:0] z);
        return 68'(x) + 68'(y) + 68'(z);
    endfunction

    // 68-bit operands are split into an unsigned low and a signed high 34-bit half
    function automatic logic signed [34:0] lo35(t_dot x);
        return $signed({1'b0, x[33:0]});
    endfunction

    function automatic logic signed [34:0] hi35(t_dot x);
        return $signed({x[67], x[67:34]});
    endfunction

    function automatic logic signed [69:0] mul35(logic signed [34:0] x,
                                                 logic signed [34:0] y);
        return 70'(x) * 70'(y);
    endfunction

    function automatic logic signed [135:0] join4(logic signed [69:0] ll,
                                                  logic signed [69:0] lh,
                                                  logic signed [69:0] hl,
                                                  logic signed [69:0] hh);
        return 136'(ll) + (136'(lh) <<< 34) + (136'(hl) <<< 34) + (136'(hh) <<< 68);
    endfunction

    always_comb begin
        n_c1 = '0;
        n_c1.p1 = {i_data.seg1_start_z, i_data.seg1_start_y, i_data.seg1_start_x};
        n_c1.p2 = {i_data.seg2_start_z, i_data.seg2_start_y, i_data.seg2_start_x};
        q1 = {i_data.seg1_end_z, i_data.seg1_end_y, i_data.seg1_end_x};
        q2 = {i_data.seg2_end_z, i_data.seg2_end_y, i_data.seg2_end_x};
        for (int i = 0; i < 3; i++) begin
            n_c1.d1[i] = sub33(q1[i], n_c1.p1[i]);
            n_c1.d2[i] = sub33(q2[i], n_c1.p2[i]);
            n_r[i]     = sub33(n_c1.p1[i], n_c1.p2[i]);
            n_rq[i]    = sub33(n_c1.p1[i], q2[i]);
            n_rp[i]    = sub33(q1[i], n_c1.p2[i]);
        end
    end

    always_comb begin
        n_c3   = r_c2;
        n_c3.a = dsum(r_pr[0][0], r_pr[0][1], r_pr[0][2]);
        n_c3.e = dsum(r_pr[1][0], r_pr[1][1], r_pr[1][2]);
        n_c3.f = dsum(r_pr[2][0], r_pr[2][1], r_pr[2][2]);
        n_c3.c = dsum(r_pr[3][0], r_pr[3][1], r_pr[3][2]);
        n_c3.b = dsum(r_pr[4][0], r_pr[4][1], r_pr[4][2]);
        n_g    = dsum(r_pr[5][0], r_pr[5][1], r_pr[5][2]);
        n_f2   = dsum(r_pr[6][0], r_pr[6][1], r_pr[6][2]);
    end

    // operand pairs: a*e, b*b, b*f, c*e
    always_comb begin
        mx[0] = r_c3.a; my[0] = r_c3.e;
        mx[1] = r_c3.b; my[1] = r_c3.b;
        mx[2] = r_c3.b; my[2] = r_c3.f;
        mx[3] = r_c3.c; my[3] = r_c3.e;
    end

    always_comb begin
        n_c6    = r_c5;
        n_lanes = '0;
        denom   = t_wide'(r_ae) - t_wide'(r_bb);
        num     = t_wide'(r_bf) - t_wide'(r_ce);
        epsw    = t_wide'({1'b0, i_eps}) << (2 * FRAC_BITS);
        n0      = -t_wide'(r_c5.c);
        n1      = -t_wide'(r_g5);
        priority if (r_adeg4 && r_edeg4) begin
            n_c6.mode = M_BOTH;
        end else if (r_adeg4) begin
            n_c6.mode = M_FIRST_DEG;
            n_lanes[0] = '{num: t_wide'(r_c5.f), den: t_wide'(r_c5.e)};
        end else if (r_edeg4) begin
            n_c6.mode = M_SECOND_DEG;
            n_lanes[0] = '{num: n0, den: t_wide'(r_c5.a)};
        end else if (denom > epsw) begin
            n_c6.mode = M_GEN;
            n_lanes[0] = '{num: num, den: denom};
        end else if (i_tpe) begin
            n_c6.mode = M_PAR2;
            n_lanes[0] = '{num: (n0 <= n1) ? n0 : n1, den: t_wide'(r_c5.a)};
            n_lanes[1] = '{num: (n0 <= n1) ? n1 : n0, den: t_wide'(r_c5.a)};
            n_lanes[2] = '{num: t_wide'((r_c5.f >= r_f25) ? r_c5.f : r_f25),
                           den: t_wide'(r_c5.e)};
        end else begin
            n_c6.mode = M_PAR1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            o_valid <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1 <= n_c1;
            r_r  <= n_r;
            r_rq <= n_rq;
            r_rp <= n_rp;

            r_c2 <= r_c1;
            for (int i = 0; i < 3; i++) begin
                r_pr[0][i] <= $signed(r_c1.d1[i]) * $signed(r_c1.d1[i]);
                r_pr[1][i] <= $signed(r_c1.d2[i]) * $signed(r_c1.d2[i]);
                r_pr[2][i] <= $signed(r_c1.d2[i]) * $signed(r_r[i]);
                r_pr[3][i] <= $signed(r_c1.d1[i]) * $signed(r_r[i]);
                r_pr[4][i] <= $signed(r_c1.d1[i]) * $signed(r_c1.d2[i]);
                r_pr[5][i] <= $signed(r_c1.d1[i]) * $signed(r_rq[i]);
                r_pr[6][i] <= $signed(r_c1.d2[i]) * $signed(r_rp[i]);
            end

            r_c3 <= n_c3;
            r_g  <= n_g;
            r_f2 <= n_f2;

            r_adeg <= r_c3.a <= t_dot'({1'b0, i_eps});
            r_edeg <= r_c3.e <= t_dot'({1'b0, i_eps});
            r_c4   <= r_c3;
            r_g4   <= r_g;
            r_f24  <= r_f2;
            for (int p = 0; p < 4; p++) begin
                r_pp[p][0] <= mul35(lo35(mx[p]), lo35(my[p]));
                r_pp[p][1] <= mul35(lo35(mx[p]), hi35(my[p]));
                r_pp[p][2] <= mul35(hi35(mx[p]), lo35(my[p]));
                r_pp[p][3] <= mul35(hi35(mx[p]), hi35(my[p]));
            end

            r_c5    <= r_c4;
            r_g5    <= r_g4;
            r_f25   <= r_f24;
            r_adeg4 <= r_adeg;
            r_edeg4 <= r_edeg;
            r_ae    <= join4(r_pp[0][0], r_pp[0][1], r_pp[0][2], r_pp[0][3]);
            r_bb    <= join4(r_pp[1][0], r_pp[1][1], r_pp[1][2], r_pp[1][3]);
            r_bf    <= join4(r_pp[2][0], r_pp[2][1], r_pp[2][2], r_pp[2][3]);
            r_ce    <= join4(r_pp[3][0], r_pp[3][1], r_pp[3][2], r_pp[3][3]);

            o_ctx   <= n_c6;
            o_lanes <= n_lanes;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sscp_div.sv
`default_nettype none
module sscp_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  sscp_pkg::t_ctx   i_ctx,
    input  sscp_pkg::t_lanes i_lanes,
    output logic             o_valid,
    output sscp_pkg::t_ctx   o_ctx,
    output sscp_pkg::t_quots o_q
);
    import sscp_pkg::*;

    localparam int NS = FRAC_BITS + 1;

    logic             r_v    [NS];
    t_ctx             r_ctx  [NS];
    logic [DW-2:0]    r_rem  [NS][3];
    logic [DW-2:0]    r_den  [NS][3];
    logic [FRAC_BITS-1:0] r_q [NS][3];
    logic             r_zero [NS][3];
    logic             r_one  [NS][3];

    logic [DW-2:0]    n_rem  [NS][3];
    logic             n_bit  [NS][3];
    logic [DW-1:0]    rem2   [NS][3];
    logic [DW-1:0]    diff   [NS][3];

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            for (int l = 0; l < 3; l++) begin
                rem2[k][l]  = {r_rem[k][l], 1'b0};
                diff[k][l]  = rem2[k][l] - {1'b0, r_den[k][l]};
                n_bit[k][l] = rem2[k][l] >= {1'b0, r_den[k][l]};
                n_rem[k][l] = n_bit[k][l] ? diff[k][l][DW-2:0] : rem2[k][l][DW-2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx[0] <= i_ctx;
            for (int l = 0; l < 3; l++) begin
                r_zero[0][l] <= (i_lanes[l].den <= 0) || (i_lanes[l].num <= 0);
                r_one[0][l]  <= i_lanes[l].num >= i_lanes[l].den;
                r_rem[0][l]  <= i_lanes[l].num[DW-2:0];
                r_den[0][l]  <= i_lanes[l].den[DW-2:0];
                r_q[0][l]    <= '0;
            end
            for (int k = 1; k < NS; k++) begin
                r_ctx[k] <= r_ctx[k-1];
                for (int l = 0; l < 3; l++) begin
                    r_zero[k][l] <= r_zero[k-1][l];
                    r_one[k][l]  <= r_one[k-1][l];
                    r_den[k][l]  <= r_den[k-1][l];
                    r_rem[k][l]  <= n_rem[k-1][l];
                    r_q[k][l]    <= {r_q[k-1][l][FRAC_BITS-2:0], n_bit[k-1][l]};
                end
            end
        end
    end

    always_comb begin
        o_valid = r_v[NS-1];
        o_ctx   = r_ctx[NS-1];
        for (int l = 0; l < 3; l++) begin
            priority if (r_zero[NS-1][l]) o_q[l] = '0;
            else if (r_one[NS-1][l])      o_q[l] = PAR_ONE;
            else                          o_q[l] = {1'b0, r_q[NS-1][l]};
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sscp_mid.sv
`default_nettype none
module sscp_mid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  sscp_pkg::t_ctx   i_ctx,
    input  sscp_pkg::t_quots i_q,
    input  logic [31:0]      i_eps,
    output logic             o_valid,
    output sscp_pkg::t_ctx   o_ctx,
    output sscp_pkg::t_lanes o_lanes
);
    import sscp_pkg::*;

    localparam int BSW = 69 + PW;

    logic r_v1;
    t_ctx r_c1;
    logic signed [BSW-1:0] r_bs;

    t_ctx   n_c1, n_c2;
    t_lanes n_lanes;
    t_wide  tnom, ef;

    always_comb begin
        n_c1    = i_ctx;
        n_c1.s  = '0;
        n_c1.t  = '0;
        n_c1.sp = i_q[1];
        n_c1.tp = i_q[2];
        unique case (i_ctx.mode)
            M_FIRST_DEG:                 n_c1.t = i_q[0];
            M_SECOND_DEG, M_GEN, M_PAR2: n_c1.s = i_q[0];
            default: ;
        endcase
        n_c1.two = (i_ctx.mode == M_PAR2) &&
                   ((64'(i_q[1] - i_q[0]) << FRAC_BITS) > 64'(i_eps));
    end

    always_comb begin
        n_c2    = r_c1;
        n_c2.tgt = TG_NONE;
        n_lanes = '0;
        tnom    = t_wide'(r_bs) + (t_wide'(r_c1.f) <<< FRAC_BITS);
        ef      = t_wide'(r_c1.e) <<< FRAC_BITS;
        if (r_c1.mode == M_GEN || r_c1.mode == M_PAR2 || r_c1.mode == M_PAR1) begin
            priority if (tnom < 0) begin
                n_c2.t   = '0;
                n_c2.tgt = TG_S;
                n_lanes[0] = '{num: -t_wide'(r_c1.c), den: t_wide'(r_c1.a)};
            end else if (tnom > ef) begin
                n_c2.t   = PAR_ONE;
                n_c2.tgt = TG_S;
                n_lanes[0] = '{num: t_wide'(r_c1.b) - t_wide'(r_c1.c),
                               den: t_wide'(r_c1.a)};
            end else begin
                n_c2.tgt = TG_T;
                n_lanes[0] = '{num: tnom, den: ef};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1    <= n_c1;
            r_bs    <= i_ctx.b * $signed({1'b0, n_c1.s});
            o_ctx   <= n_c2;
            o_lanes <= n_lanes;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sscp_back.sv
`default_nettype none
module sscp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  sscp_pkg::t_ctx   i_ctx,
    input  sscp_pkg::t_quots i_q,
    output logic             o_valid,
    output sscp_pkg::t_out   o_res0,
    output sscp_pkg::t_out   o_res1
);
    import sscp_pkg::*;

    localparam int PRW = 34 + PW;

    logic r_v1, r_v2, r_v3;
    logic signed [PRW-1:0] r_prd [4][3];
    t_vec32 r_p1, r_p2;
    t_par   r_par1 [4], r_par2 [4], r_par3 [4];
    logic   r_two1, r_two2, r_two3;
    logic [31:0] r_pt2 [4][3], r_pt3 [4][3];
    logic [63:0] r_sq [3];

    t_par s_v, t_v;
    logic signed [32:0] dd [3];
    logic [31:0] u [3];
    logic [64:0] sum01, sum012;
    logic [63:0] sat01, dist_sum;

    always_comb begin
        s_v = i_ctx.s;
        t_v = i_ctx.t;
        unique case (i_ctx.tgt)
            TG_S:    s_v = i_q[0];
            TG_T:    t_v = i_q[0];
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dd[i] = $signed(r_pt2[0][i]) - $signed(r_pt2[1][i]);
            u[i]  = 32'(dd[i][32] ? -dd[i] : dd[i]);
        end
        sum01    = {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
        sat01    = sum01[64] ? '1 : sum01[63:0];
        sum012   = {1'b0, sat01} + {1'b0, r_sq[2]};
        dist_sum = sum012[64] ? '1 : sum012[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= i_ctx.p1;
            r_p2 <= i_ctx.p2;
            r_par1[0] <= s_v;
            r_par1[1] <= t_v;
            r_par1[2] <= i_ctx.sp;
            r_par1[3] <= i_ctx.tp;
            r_two1 <= i_ctx.two;
            for (int i = 0; i < 3; i++) begin
                r_prd[0][i] <= $signed(i_ctx.d1[i]) * $signed({1'b0, s_v});
                r_prd[1][i] <= $signed(i_ctx.d2[i]) * $signed({1'b0, t_v});
                r_prd[2][i] <= $signed(i_ctx.d1[i]) * $signed({1'b0, i_ctx.sp});
                r_prd[3][i] <= $signed(i_ctx.d2[i]) * $signed({1'b0, i_ctx.tp});
            end

            r_par2 <= r_par1;
            r_two2 <= r_two1;
            for (int i = 0; i < 3; i++) begin
                r_pt2[0][i] <= 32'($signed(r_p1[i]) + (r_prd[0][i] >>> FRAC_BITS));
                r_pt2[1][i] <= 32'($signed(r_p2[i]) + (r_prd[1][i] >>> FRAC_BITS));
                r_pt2[2][i] <= 32'($signed(r_p1[i]) + (r_prd[2][i] >>> FRAC_BITS));
                r_pt2[3][i] <= 32'($signed(r_p2[i]) + (r_prd[3][i] >>> FRAC_BITS));
            end

            r_par3 <= r_par2;
            r_two3 <= r_two2;
            r_pt3  <= r_pt2;
            for (int i = 0; i < 3; i++) r_sq[i] <= 64'(u[i]) * 64'(u[i]);

            o_res0 <= '{param_first: to_q16(r_par3[0]), param_second: to_q16(r_par3[1]),
                        near_first_x: r_pt3[0][0], near_first_y: r_pt3[0][1],
                        near_first_z: r_pt3[0][2], near_second_x: r_pt3[1][0],
                        near_second_y: r_pt3[1][1], near_second_z: r_pt3[1][2],
                        dist_squared: dist_sum, point_count: r_two3 ? 2'd2 : 2'd1,
                        last_result: !r_two3};
            o_res1 <= '{param_first: to_q16(r_par3[2]), param_second: to_q16(r_par3[3]),
                        near_first_x: r_pt3[2][0], near_first_y: r_pt3[2][1],
                        near_first_z: r_pt3[2][2], near_second_x: r_pt3[3][0],
                        near_second_y: r_pt3[3][1], near_second_z: r_pt3[3][2],
                        dist_squared: dist_sum, point_count: 2'd2, last_result: 1'b1};
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/segment_segment_closest_points_unit.sv
// Channel  Direction  Handshake            Payload
// input    in         i_valid / o_stall    i_data  (sscp_pkg::t_in)
// result   out        o_valid / i_stall    o_data  (sscp_pkg::t_out)
// config   in         APB psel/penable     paddr, pwdata, prdata
//
// Two restoring Q1.16 dividers of FRAC_BITS+1 stages, one quotient bit per stage, plus
// 13 front, middle, back and output stages. One item enters per cycle unless stalled;
// an item with two results stalls input until both are taken. All stages advance
// together; a stall while a result waits at the output freezes the whole pipeline.
// Reset is synchronous, clears the valid bits and loads the register defaults.
`default_nettype none
module segment_segment_closest_points_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  sscp_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output sscp_pkg::t_out o_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import sscp_pkg::*;

    logic [31:0] r_eps;
    logic        r_tpe;
    logic        r_ov, r_phase;
    t_out        r_res0, r_res1;
    logic        en;

    logic   f_v, d1_v, m_v, d2_v, b_v;
    t_ctx   f_ctx, d1_ctx, m_ctx, d2_ctx;
    t_lanes f_lanes, m_lanes;
    t_quots d1_q, d2_q;
    t_out   b_res0, b_res1;

    assign en      = !r_ov || (!i_stall && (r_res0.last_result || r_phase));
    assign o_stall = !en;
    assign o_valid = r_ov;
    assign o_data  = r_phase ? r_res1 : r_res0;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_TPE) ? {31'd0, r_tpe} : r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= 32'd4096;
            r_tpe <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_EPS: r_eps <= pwdata;
                REG_TPE: r_tpe <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_phase <= 1'b0;
        end else if (en) begin
            r_ov    <= b_v;
            r_phase <= 1'b0;
        end else if (r_ov && !i_stall) begin
            r_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res0 <= b_res0;
            r_res1 <= b_res1;
        end
    end

    sscp_front u_front (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_valid && !o_stall), .i_data,
        .i_eps(r_eps), .i_tpe(r_tpe),
        .o_valid(f_v), .o_ctx(f_ctx), .o_lanes(f_lanes)
    );

    sscp_div u_div1 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(f_v), .i_ctx(f_ctx), .i_lanes(f_lanes),
        .o_valid(d1_v), .o_ctx(d1_ctx), .o_q(d1_q)
    );

    sscp_mid u_mid (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(d1_v), .i_ctx(d1_ctx), .i_q(d1_q),
        .i_eps(r_eps), .o_valid(m_v), .o_ctx(m_ctx), .o_lanes(m_lanes)
    );

    sscp_div u_div2 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(m_v), .i_ctx(m_ctx), .i_lanes(m_lanes),
        .o_valid(d2_v), .o_ctx(d2_ctx), .o_q(d2_q)
    );

    sscp_back u_back (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(d2_v), .i_ctx(d2_ctx), .i_q(d2_q),
        .o_valid(b_v), .o_res0(b_res0), .o_res1(b_res1)
    );

endmodule
`default_nettype wire

FILE: rtl/core/sscp_checker.sv
`default_nettype none
`include "segment_segment_closest_points_unit_assert.svh"
module sscp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_stall,
    input sscp_pkg::t_out o_data
);
    import sscp_pkg::*;

    `SSCP_ASSERT(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_data))
    `SSCP_ASSERT(a_single_last, i_clk, i_rst_n, o_valid && o_data.point_count == 2'd1 |-> o_data.last_result)
    `SSCP_ASSERT(a_second_follows, i_clk, i_rst_n, o_valid && !i_stall && !o_data.last_result |=> o_valid && o_data.last_result && o_data.point_count == 2'd2)
    `SSCP_ASSERT(a_param_range, i_clk, i_rst_n, o_valid |-> o_data.param_first <= 17'd65536 && o_data.param_second <= 17'd65536)
    `SSCP_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind segment_segment_closest_points_unit sscp_checker u_sscp_checker (.*);
`default_nettype wire

FILE: tb/segment_segment_closest_points_unit_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module segment_segment_closest_points_unit_tb;
    import sscp_pkg::*;

    typedef logic signed [159:0] wide_t;

    localparam int DRAIN     = 60;
    localparam int QUIET_MAX = 20000;
    localparam logic [2:0] ADDR_EPS = 3'(4 * REG_EPS);
    localparam logic [2:0] ADDR_TPE = 3'(4 * REG_TPE);

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    t_in    i_data;
    logic   o_valid;
    logic   i_stall;
    t_out   o_data;
    logic   psel;
    logic   penable;
    logic   pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic   pready;

    bit calm;
    int quiet = 0;

    segment_segment_closest_points_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    class closest_pair_board;
        logic [31:0] eps_thr;
        bit          pair_en;
        t_out        pending[$];
        int          errs;

        function new();
            eps_thr = 32'd4096;
            pair_en = 1'b1;
            errs    = 0;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
            errs++;
        endtask

        function wide_t dot3(longint u[3], longint v[3]);
            return wide_t'(u[0]) * wide_t'(v[0]) + wide_t'(u[1]) * wide_t'(v[1])
                 + wide_t'(u[2]) * wide_t'(v[2]);
        endfunction

        function t_par ratio(wide_t num, wide_t den);
            if (den <= 0 || num <= 0) return '0;
            if (num >= den) return PAR_ONE;
            return t_par'((num <<< FRAC_BITS) / den);
        endfunction

        function longint along(longint p, longint d, t_par par);
            longint prod;
            prod = d * longint'(par);
            return p + (prod >>> FRAC_BITS);
        endfunction

        function t_out pack_result(t_par s, t_par t, longint p1[3], longint d1[3],
                                   longint p2[3], longint d2[3], logic [63:0] dsq,
                                   logic [1:0] cnt, logic last);
            t_out o;
            o.param_first   = to_q16(s);
            o.param_second  = to_q16(t);
            o.near_first_x  = 32'(along(p1[0], d1[0], s));
            o.near_first_y  = 32'(along(p1[1], d1[1], s));
            o.near_first_z  = 32'(along(p1[2], d1[2], s));
            o.near_second_x = 32'(along(p2[0], d2[0], t));
            o.near_second_y = 32'(along(p2[1], d2[1], t));
            o.near_second_z = 32'(along(p2[2], d2[2], t));
            o.dist_squared  = dsq;
            o.point_count   = cnt;
            o.last_result   = last;
            return o;
        endfunction

        function void note(t_in x);
            longint p1[3], q1[3], p2[3], q2[3], d1[3], d2[3], r[3], rq[3], rp[3];
            wide_t a, e, f, c, b, eps, denom, tnom, n0, n1, f2, ef;
            t_par s, t, sp, tp;
            logic [63:0] dsq, u, sq;
            longint dd;
            int cnt;
            bit lo0;
            s = '0; t = '0; sp = '0; tp = '0; cnt = 1; dsq = '0;
            p1 = '{longint'(x.seg1_start_x), longint'(x.seg1_start_y),
                   longint'(x.seg1_start_z)};
            q1 = '{longint'(x.seg1_end_x), longint'(x.seg1_end_y), longint'(x.seg1_end_z)};
            p2 = '{longint'(x.seg2_start_x), longint'(x.seg2_start_y),
                   longint'(x.seg2_start_z)};
            q2 = '{longint'(x.seg2_end_x), longint'(x.seg2_end_y), longint'(x.seg2_end_z)};
            for (int i = 0; i < 3; i++) begin
                d1[i] = q1[i] - p1[i];
                d2[i] = q2[i] - p2[i];
                r[i]  = p1[i] - p2[i];
                rq[i] = p1[i] - q2[i];
                rp[i] = q1[i] - p2[i];
            end
            a = dot3(d1, d1);
            e = dot3(d2, d2);
            f = dot3(d2, r);
            c = dot3(d1, r);
            eps = wide_t'(eps_thr);
            if (a <= eps && e <= eps) begin
                s = '0; t = '0;
            end else if (a <= eps) begin
                t = ratio(f, e);
            end else if (e <= eps) begin
                s = ratio(-c, a);
            end else begin
                b = dot3(d1, d2);
                denom = a * e - b * b;
                ef = e <<< FRAC_BITS;
                if (denom > (eps <<< (2 * FRAC_BITS))) begin
                    s = ratio(b * f - c * e, denom);
                end else if (pair_en) begin
                    n0 = -c;
                    n1 = -dot3(d1, rq);
                    f2 = dot3(d2, rp);
                    lo0 = (n0 <= n1);
                    s  = ratio(lo0 ? n0 : n1, a);
                    sp = ratio(lo0 ? n1 : n0, a);
                    tp = ratio((f >= f2) ? f : f2, e);
                    if ((64'(32'(sp) - 32'(s)) << FRAC_BITS) > 64'(eps_thr)) cnt = 2;
                end else begin
                    s = '0;
                end
                tnom = b * wide_t'(s) + (f <<< FRAC_BITS);
                if (tnom < 0) begin
                    t = '0;
                    s = ratio(-c, a);
                end else if (tnom > ef) begin
                    t = PAR_ONE;
                    s = ratio(b - c, a);
                end else begin
                    t = ratio(tnom, ef);
                end
            end
            for (int i = 0; i < 3; i++) begin
                dd = along(p1[i], d1[i], s) - along(p2[i], d2[i], t);
                u  = (dd < 0) ? 64'(-dd) : 64'(dd);
                sq = u * u;
                dsq = (dsq > ~64'd0 - sq) ? ~64'd0 : dsq + sq;
            end
            pending.push_back(pack_result(s, t, p1, d1, p2, d2, dsq, 2'(cnt), cnt == 1));
            if (cnt == 2) pending.push_back(pack_result(sp, tp, p1, d1, p2, d2, dsq, 2'd2, 1'b1));
        endfunction

        task check(t_out got);
            t_out w;
            if (pending.size() == 0) begin
                report("unexpected item", 64'(got.dist_squared), '0);
                return;
            end
            w = pending.pop_front();
            if (got.param_first !== w.param_first)
                report("param_first", 64'(got.param_first), 64'(w.param_first));
            if (got.param_second !== w.param_second)
                report("param_second", 64'(got.param_second), 64'(w.param_second));
            if (got.near_first_x !== w.near_first_x)
                report("near_first_x", 64'(got.near_first_x), 64'(w.near_first_x));
            if (got.near_first_y !== w.near_first_y)
                report("near_first_y", 64'(got.near_first_y), 64'(w.near_first_y));
            if (got.near_first_z !== w.near_first_z)
                report("near_first_z", 64'(got.near_first_z), 64'(w.near_first_z));
            if (got.near_second_x !== w.near_second_x)
                report("near_second_x", 64'(got.near_second_x), 64'(w.near_second_x));
            if (got.near_second_y !== w.near_second_y)
                report("near_second_y", 64'(got.near_second_y), 64'(w.near_second_y));
            if (got.near_second_z !== w.near_second_z)
                report("near_second_z", 64'(got.near_second_z), 64'(w.near_second_z));
            if (got.dist_squared !== w.dist_squared)
                report("dist_squared", got.dist_squared, w.dist_squared);
            if (got.point_count !== w.point_count)
                report("point_count", 64'(got.point_count), 64'(w.point_count));
            if (got.last_result !== w.last_result)
                report("last_result", 64'(got.last_result), 64'(w.last_result));
        endtask
    endclass

    closest_pair_board board = new();

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) board.check(o_data);
            if (i_valid && !o_stall) board.note(i_data);
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet >= QUIET_MAX) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);
    end

    function automatic logic signed [31:0] rnd(int bits);
        return $signed($urandom) >>> (32 - bits);
    endfunction

    function automatic t_in make_item(int kind);
        t_in x;
        logic signed [31:0] p1[3], q1[3], p2[3], q2[3], d[3];
        int m1, m2, k;
        m1 = $urandom_range(4, 1);
        m2 = $urandom_range(8) - 4;
        if (m2 == 0) m2 = 1;
        k = $urandom_range(6) - 3;
        for (int i = 0; i < 3; i++) begin
            d[i] = rnd(12);
            case (kind)
                0: begin
                    p1[i] = $urandom; q1[i] = $urandom; p2[i] = $urandom; q2[i] = $urandom;
                end
                1: begin
                    p1[i] = rnd(20); q1[i] = rnd(20); p2[i] = rnd(20); q2[i] = rnd(20);
                end
                2: begin
                    p1[i] = rnd(20); q1[i] = p1[i] + rnd(5); p2[i] = rnd(20); q2[i] = rnd(20);
                end
                3: begin
                    p1[i] = rnd(20); q1[i] = rnd(20); p2[i] = rnd(20); q2[i] = p2[i] + rnd(5);
                end
                4: begin
                    p1[i] = rnd(20); q1[i] = p1[i]; p2[i] = rnd(20); q2[i] = p2[i] + rnd(5);
                end
                default: begin
                    p1[i] = rnd(20);
                    q1[i] = p1[i] + d[i] * m1;
                    p2[i] = p1[i] + d[i] * k + ((kind == 6) ? 32'sd0 : rnd(6));
                    q2[i] = p2[i] + d[i] * m2;
                end
            endcase
        end
        x.seg1_start_x = p1[0]; x.seg1_start_y = p1[1]; x.seg1_start_z = p1[2];
        x.seg1_end_x   = q1[0]; x.seg1_end_y   = q1[1]; x.seg1_end_z   = q1[2];
        x.seg2_start_x = p2[0]; x.seg2_start_y = p2[1]; x.seg2_start_z = p2[2];
        x.seg2_end_x   = q2[0]; x.seg2_end_y   = q2[1]; x.seg2_end_z   = q2[2];
        return x;
    endfunction

    task automatic send(t_in x);
        while (!calm && $urandom_range(99) < 33) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_data  = x;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        @(negedge i_clk);
        i_valid = 1'b0;
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] eps, bit en);
        apb_write(ADDR_EPS, eps);
        apb_write(ADDR_TPE, {31'd0, en});
        board.eps_thr = eps;
        board.pair_en = en;
    endtask

    task automatic random_run(int n);
        int kind;
        for (int j = 0; j < n; j++) begin
            calm = (j >= n / 3 && j < n / 2);
            kind = $urandom_range(99);
            if (kind < 15) kind = 0;
            else if (kind < 35) kind = 1;
            else if (kind < 45) kind = 2;
            else if (kind < 55) kind = 3;
            else if (kind < 62) kind = 4;
            else if (kind < 92) kind = 5;
            else kind = 6;
            send(make_item(kind));
        end
        calm = 1'b0;
    endtask

    initial begin
        t_in x;
        calm = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // corners of the coordinate range
        send('1 >> 1 | {12{32'h7fffffff}});
        send({12{32'h80000000}});
        send({{3{32'h80000000}}, {3{32'h7fffffff}}, {3{32'h7fffffff}}, {3{32'h80000000}}});
        send({{3{32'h80000000}}, {3{32'h7fffffff}}, {3{32'h80000000}}, {3{32'h7fffffff}}});
        send({{3{32'h7fffffff}}, {3{32'h80000000}}, {3{32'h00000000}}, {3{32'hffffffff}}});
        send('0);
        x = make_item(6);
        x.seg2_start_x = x.seg1_start_x; x.seg2_start_y = x.seg1_start_y;
        x.seg2_start_z = x.seg1_start_z; x.seg2_end_x = x.seg1_end_x;
        x.seg2_end_y = x.seg1_end_y; x.seg2_end_z = x.seg1_end_z;
        send(x);
        for (int k = 0; k < 7; k++) begin
            send(make_item(k));
            send(make_item(k));
        end
        settle();

        random_run(340);
        settle();
        set_regs(32'd0, 1'b1);
        random_run(340);
        settle();
        set_regs(32'd0, 1'b0);
        random_run(340);
        settle();
        set_regs(32'hffffffff, 1'b1);
        random_run(200);
        settle();
        set_regs($urandom_range(1 << 20), 1'b0);
        random_run(200);
        settle();
        set_regs(32'd4096, 1'b1);
        random_run(300);
        settle();

        if (board.errs == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
